// ===== src/gift64_pkg.sv =====
package gift64_pkg;

  localparam int unsigned RoundCount = 28;
  localparam int unsigned BlkW       = 64;
  localparam int unsigned KeyW       = 64;

  typedef enum logic {
    CFG_KEY_HIGH = 1'b0,
    CFG_KEY_LOW  = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    DIR_ENC = 1'b0,
    DIR_DEC = 1'b1
  } dir_e;

  // per-round key material
  typedef struct packed {
    logic [15:0] k1;
    logic [15:0] k0;
    logic [5:0]  rc;
  } rnd_key_t;

  typedef rnd_key_t [RoundCount-1:0] rnd_key_arr_t;

  localparam logic [3:0] SboxFwd [16] = '{
    4'h1, 4'ha, 4'h4, 4'hc, 4'h6, 4'hf, 4'h3, 4'h9,
    4'h2, 4'hd, 4'hb, 4'h7, 4'h5, 4'h0, 4'h8, 4'he
  };

  localparam logic [3:0] SboxInv [16] = '{
    4'hd, 4'h0, 4'h8, 4'h6, 4'h2, 4'hc, 4'h4, 4'hb,
    4'he, 4'h7, 4'h1, 4'ha, 4'h3, 4'h9, 4'hf, 4'h5
  };

  localparam logic [5:0] BitDest [64] = '{
    6'd0,  6'd17, 6'd34, 6'd51, 6'd48, 6'd1,  6'd18, 6'd35,
    6'd32, 6'd49, 6'd2,  6'd19, 6'd16, 6'd33, 6'd50, 6'd3,
    6'd4,  6'd21, 6'd38, 6'd55, 6'd52, 6'd5,  6'd22, 6'd39,
    6'd36, 6'd53, 6'd6,  6'd23, 6'd20, 6'd37, 6'd54, 6'd7,
    6'd8,  6'd25, 6'd42, 6'd59, 6'd56, 6'd9,  6'd26, 6'd43,
    6'd40, 6'd57, 6'd10, 6'd27, 6'd24, 6'd41, 6'd58, 6'd11,
    6'd12, 6'd29, 6'd46, 6'd63, 6'd60, 6'd13, 6'd30, 6'd47,
    6'd44, 6'd61, 6'd14, 6'd31, 6'd28, 6'd45, 6'd62, 6'd15
  };

  function automatic logic [BlkW-1:0] sub_fwd(input logic [BlkW-1:0] x);
    logic [BlkW-1:0] y;
    y = '0;
    for (int i = 0; i < 16; i++) begin
      y[4*i +: 4] = SboxFwd[x[4*i +: 4]];
    end
    return y;
  endfunction

  function automatic logic [BlkW-1:0] sub_inv(input logic [BlkW-1:0] x);
    logic [BlkW-1:0] y;
    y = '0;
    for (int i = 0; i < 16; i++) begin
      y[4*i +: 4] = SboxInv[x[4*i +: 4]];
    end
    return y;
  endfunction

  function automatic logic [BlkW-1:0] perm_fwd(input logic [BlkW-1:0] x);
    logic [BlkW-1:0] y;
    y = '0;
    for (int i = 0; i < 64; i++) begin
      y[BitDest[i]] = x[i];
    end
    return y;
  endfunction

  function automatic logic [BlkW-1:0] perm_inv(input logic [BlkW-1:0] x);
    logic [BlkW-1:0] y;
    y = '0;
    for (int i = 0; i < 64; i++) begin
      y[i] = x[BitDest[i]];
    end
    return y;
  endfunction

  // round key, round constant and the fixed top-bit flip
  function automatic logic [BlkW-1:0] add_key(input logic [BlkW-1:0] x,
                                               input rnd_key_t k);
    logic [BlkW-1:0] y;
    y = x;
    for (int i = 0; i < 16; i++) begin
      y[4*i+1] = y[4*i+1] ^ k.k1[i];
      y[4*i]   = y[4*i]   ^ k.k0[i];
    end
    y[63] = ~y[63];
    y[23] = y[23] ^ k.rc[5];
    y[19] = y[19] ^ k.rc[4];
    y[15] = y[15] ^ k.rc[3];
    y[11] = y[11] ^ k.rc[2];
    y[7]  = y[7]  ^ k.rc[1];
    y[3]  = y[3]  ^ k.rc[0];
    return y;
  endfunction

  // Key schedule: rotations and word moves only, so this is pure wiring.
  function automatic rnd_key_arr_t key_sched(input logic [KeyW-1:0] hi_in,
                                             input logic [KeyW-1:0] lo_in);
    rnd_key_arr_t ks;
    logic [KeyW-1:0] hi;
    logic [KeyW-1:0] lo;
    logic [5:0]      c;
    logic [15:0]     k1;
    logic [15:0]     k0;
    hi = hi_in;
    lo = lo_in;
    c  = '0;
    for (int r = 0; r < RoundCount; r++) begin
      k1 = lo[31:16];
      k0 = lo[15:0];
      c  = {c[4:0], ~(c[5] ^ c[4])};
      ks[r].k1 = k1;
      ks[r].k0 = k0;
      ks[r].rc = c;
      lo = {hi[31:0], lo[63:32]};
      hi = {k1[1:0], k1[15:2], k0[11:0], k0[15:12], hi[63:32]};
    end
    return ks;
  endfunction

endpackage

// ===== src/gift64_block_cipher.sv =====
// GIFT-64 cipher, one round per pipeline stage (28 stages).
// An accepted input beat passes through every stage register before it reaches the result beat.
// Throughput: one block per cycle; bubbles collapse, so a stalled output only
// backs up the input once every stage holds a block.
// Reset (async, active low) clears all stage valid bits and both key registers.
module gift64_block_cipher
  import gift64_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  // configuration
  input  logic            cfg_we_i,
  input  logic            cfg_idx_i,
  input  logic [KeyW-1:0] cfg_wdata_i,
  // input channel
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic            req_type_i,
  input  logic [BlkW-1:0] data_block_i,
  // output channel
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [BlkW-1:0] result_block_o
);

  localparam int unsigned Last = RoundCount - 1;

  // -------------------------------------------------------------------------
  // Key registers. They must be written by the user only while the pipe is empty (the
  // block does not enforce it), so the round keys can be derived combinationally from them.
  // -------------------------------------------------------------------------
  logic [KeyW-1:0] key_high_q;
  logic [KeyW-1:0] key_low_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_KEY_HIGH: key_high_q <= cfg_wdata_i;
        CFG_KEY_LOW:  key_low_q  <= cfg_wdata_i;
        default:      ;
      endcase
    end
  end

  rnd_key_arr_t rk;
  assign rk = key_sched(key_high_q, key_low_q);

  // -------------------------------------------------------------------------
  // Pipeline. Stage s holds the block after round s (encrypt) or after the
  // inverse of round Last-s (decrypt). A stage loads when it is empty or
  // when its contents move on.
  // -------------------------------------------------------------------------
  logic [RoundCount-1:0] vld_q;
  logic [RoundCount-1:0] en;
  dir_e                  dir_q [RoundCount];
  logic [BlkW-1:0]       blk_q [RoundCount];
  logic [BlkW-1:0]       blk_d [RoundCount];

  assign en[Last] = !vld_q[Last] || !out_stall_i;

  for (genvar s = 0; s < Last; s++) begin : g_en
    assign en[s] = !vld_q[s] || en[s+1];
  end

  for (genvar s = 0; s < RoundCount; s++) begin : g_stage
    dir_e            dir_in;
    logic [BlkW-1:0] blk_in;
    logic            vld_in;
    rnd_key_t        key_sel;

    if (s == 0) begin : g_head
      assign dir_in = dir_e'(req_type_i);
      assign blk_in = data_block_i;
      assign vld_in = in_valid_i;
    end else begin : g_body
      assign dir_in = dir_q[s-1];
      assign blk_in = blk_q[s-1];
      assign vld_in = vld_q[s-1];
    end

    // decryption walks the key schedule backward
    assign key_sel = (dir_in == DIR_DEC) ? rk[Last-s] : rk[s];

    gift64_round u_round (
      .dir_i (dir_in),
      .key_i (key_sel),
      .blk_i (blk_in),
      .blk_o (blk_d[s])
    );

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en[s]) begin
        vld_q[s] <= vld_in;
      end
    end

    // payload carries no reset
    always_ff @(posedge clk_i) begin
      if (en[s] && vld_in) begin
        blk_q[s] <= blk_d[s];
        dir_q[s] <= dir_in;
      end
    end
  end

  assign in_stall_o     = !en[0];
  assign out_valid_o    = vld_q[Last];
  assign result_block_o = blk_q[Last];

  // -------------------------------------------------------------------------
  // Assertions
  // -------------------------------------------------------------------------
  a_in_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> vld_q[0])
    else $error("accepted beat did not land in stage 0");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&vld_q))
    else $error("input stalled while a stage is empty");

  a_head_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[0] && !en[0]) |=> (vld_q[0] && $stable(blk_q[0])))
    else $error("stage 0 lost or changed a held block");

  a_tail_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_stall_i && vld_q[Last-1]) |=> vld_q[Last])
    else $error("block dropped before the last stage");

endmodule

// ===== src/gift64_round.sv =====
module gift64_round
  import gift64_pkg::*;
(
  input  dir_e            dir_i,
  input  rnd_key_t        key_i,
  input  logic [BlkW-1:0] blk_i,
  output logic [BlkW-1:0] blk_o
);

  logic [BlkW-1:0] enc_blk;
  logic [BlkW-1:0] dec_blk;

  // encrypt: sbox, permute, add key; decrypt: the inverse steps reversed
  assign enc_blk = add_key(perm_fwd(sub_fwd(blk_i)), key_i);
  assign dec_blk = sub_inv(perm_inv(add_key(blk_i, key_i)));

  assign blk_o = (dir_i == DIR_DEC) ? dec_blk : enc_blk;

endmodule

// ===== tb/gift64_block_cipher_test.sv =====
module gift64_block_cipher_test;
  import gift64_pkg::*;

  // Longest legal run of cycles with no accepted beat is the receiver hold-off
  // (HOLD_CYCLES); the watchdog allows several times that.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_TAIL     = 40;   // pipeline is 28 deep
  localparam int PHASE_ITEMS    = 200;
  localparam int PHASE_COUNT    = 6;

  // nibble substitution tables
  localparam logic [3:0] SBOX_ENC [16] = '{
    4'h1, 4'ha, 4'h4, 4'hc, 4'h6, 4'hf, 4'h3, 4'h9,
    4'h2, 4'hd, 4'hb, 4'h7, 4'h5, 4'h0, 4'h8, 4'he
  };
  localparam logic [3:0] SBOX_DEC [16] = '{
    4'hd, 4'h0, 4'h8, 4'h6, 4'h2, 4'hc, 4'h4, 4'hb,
    4'he, 4'h7, 4'h1, 4'ha, 4'h3, 4'h9, 4'hf, 4'h5
  };

  logic            clk        = 1'b0;
  logic            rst_n      = 1'b0;
  logic            cfg_we     = 1'b0;
  cfg_idx_e        cfg_idx    = CFG_KEY_HIGH;
  logic [KeyW-1:0] cfg_wdata  = '0;
  logic            in_valid   = 1'b0;
  logic            in_stall;
  dir_e            req_type   = DIR_ENC;
  logic [BlkW-1:0] data_block = '0;
  logic            out_valid;
  logic            out_stall  = 1'b0;
  logic [BlkW-1:0] result_block;

  // key registers as the block should hold them
  logic [KeyW-1:0] key_hi_model = '0;
  logic [KeyW-1:0] key_lo_model = '0;

  logic [BlkW-1:0] pending_blocks [$];   // expected result beats, oldest first
  logic [BlkW-1:0] want_block;
  logic [BlkW-1:0] last_cipher = '0;
  int              mismatch_count = 0;
  int              idle_cycles    = 0;
  int              tx_idle_pct    = 24;
  int              rx_idle_pct    = 24;
  bit              hold_req       = 1'b0;
  int              hold_left      = 0;

  gift64_block_cipher DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .req_type_i     (req_type),
    .data_block_i   (data_block),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .result_block_o (result_block)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Cipher predictor
  // ---------------------------------------------------------------------------

  // Destination of block bit i under the GIFT-64 bit permutation.
  function automatic int unsigned bit_target(input int unsigned i);
    int unsigned lane;
    int unsigned grp;
    lane = i % 4;
    grp  = (i % 16) / 4;
    return 4 * (i / 16) + 16 * ((3 * grp + lane) % 4) + lane;
  endfunction

  function automatic logic [15:0] rotr16(input logic [15:0] v, input int unsigned r);
    return (v >> r) | (v << (16 - r));
  endfunction

  // key words into bits 4i+1 / 4i, constant into the fixed six bits, top bit flipped
  function automatic logic [BlkW-1:0] add_round_key(input logic [BlkW-1:0] x,
                                                    input logic [15:0] w1,
                                                    input logic [15:0] w0,
                                                    input logic [5:0] c);
    for (int i = 0; i < 16; i++) begin
      x[4*i+1] ^= w1[i];
      x[4*i]   ^= w0[i];
    end
    x[63] = ~x[63];
    x[23] ^= c[5];
    x[19] ^= c[4];
    x[15] ^= c[3];
    x[11] ^= c[2];
    x[7]  ^= c[1];
    x[3]  ^= c[0];
    return x;
  endfunction

  function automatic logic [BlkW-1:0] gift_crypt_block(input dir_e dir,
                                                       input logic [BlkW-1:0] blk,
                                                       input logic [KeyW-1:0] khi,
                                                       input logic [KeyW-1:0] klo);
    logic [15:0]     w1 [RoundCount];
    logic [15:0]     w0 [RoundCount];
    logic [5:0]      rc [RoundCount];
    logic [KeyW-1:0] hi;
    logic [KeyW-1:0] lo;
    logic [5:0]      c;
    logic [15:0]     a;
    logic [15:0]     b;
    logic [BlkW-1:0] x;
    logic [BlkW-1:0] y;
    hi = khi;
    lo = klo;
    c  = '0;
    // round keys and constants for all rounds up front; decrypt walks them backwards
    for (int r = 0; r < RoundCount; r++) begin
      a = lo[31:16];
      b = lo[15:0];
      c = {c[4:0], ~(c[5] ^ c[4])};
      w1[r] = a;
      w0[r] = b;
      rc[r] = c;
      lo = {hi[31:0], lo[63:32]};
      hi = {rotr16(a, 2), rotr16(b, 12), hi[63:32]};
    end
    x = blk;
    if (dir == DIR_ENC) begin
      for (int r = 0; r < RoundCount; r++) begin
        for (int n = 0; n < 16; n++) y[4*n +: 4] = SBOX_ENC[x[4*n +: 4]];
        for (int i = 0; i < 64; i++) x[bit_target(i)] = y[i];
        x = add_round_key(x, w1[r], w0[r], rc[r]);
      end
    end else begin
      for (int r = RoundCount - 1; r >= 0; r--) begin
        x = add_round_key(x, w1[r], w0[r], rc[r]);
        for (int i = 0; i < 64; i++) y[i] = x[bit_target(i)];
        for (int n = 0; n < 16; n++) x[4*n +: 4] = SBOX_DEC[y[4*n +: 4]];
      end
    end
    return x;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic logic [63:0] rand_block();
    logic [63:0] v;
    case ($urandom_range(15))
      0:       v = '0;
      1:       v = '1;
      2:       v = 64'h1 << $urandom_range(63);
      3:       v = ~(64'h1 << $urandom_range(63));
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  // Offer one beat, holding it until accepted. in_valid is only lowered inside
  // an idle gap, so back-to-back beats never see a low/high pair in one step.
  task automatic send_block(input dir_e dir, input logic [BlkW-1:0] blk);
    logic [BlkW-1:0] want;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    req_type   <= dir;
    data_block <= blk;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    want = gift_crypt_block(dir, blk, key_hi_model, key_lo_model);
    pending_blocks.push_back(want);
    if (dir == DIR_ENC) last_cipher = want;
  endtask

  task automatic drain_pipeline(input int tail);
    in_valid <= 1'b0;
    while (pending_blocks.size() != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [KeyW-1:0] v);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_KEY_HIGH: key_hi_model = v;
      CFG_KEY_LOW:  key_lo_model = v;
      default:      ;
    endcase
    @(posedge clk);
  endtask

  // keys only change with the pipeline empty
  task automatic set_key(input logic [KeyW-1:0] hi, input logic [KeyW-1:0] lo);
    drain_pipeline(4);
    write_reg(CFG_KEY_HIGH, hi);
    write_reg(CFG_KEY_LOW, lo);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset key of all zeros, data extremes, and a decrypt of a fresh ciphertext.
  task automatic test_reset_key();
    send_block(DIR_ENC, '0);
    send_block(DIR_ENC, '1);
    send_block(DIR_DEC, '0);
    send_block(DIR_DEC, '1);
    send_block(DIR_ENC, 64'h0000_0000_0000_0001);
    send_block(DIR_ENC, 64'h8000_0000_0000_0000);
    send_block(DIR_DEC, last_cipher);
  endtask

  task automatic test_key_extremes();
    set_key('1, '1);
    send_block(DIR_ENC, '0);
    send_block(DIR_DEC, '1);
    send_block(DIR_ENC, 64'h5555_5555_5555_5555);
    send_block(DIR_DEC, 64'haaaa_aaaa_aaaa_aaaa);
    set_key('1, '0);
    send_block(DIR_ENC, 64'h0123_4567_89ab_cdef);
    send_block(DIR_DEC, last_cipher);
    set_key('0, '1);
    send_block(DIR_ENC, 64'hfedc_ba98_7654_3210);
    send_block(DIR_DEC, last_cipher);
    set_key(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
    send_block(DIR_ENC, 64'hf0f0_f0f0_0f0f_0f0f);
    send_block(DIR_DEC, 64'h0f0f_0f0f_f0f0_f0f0);
    // lone key bits: k0 bit 0, then k7 bit 15
    set_key('0, 64'h1);
    send_block(DIR_ENC, '0);
    set_key(64'h8000_0000_0000_0000, '0);
    send_block(DIR_DEC, '0);
  endtask

  // Random keys per phase; a quarter of the beats decrypt the last ciphertext.
  task automatic test_random_traffic();
    dir_e dir;
    for (int p = 0; p < PHASE_COUNT; p++) begin
      if (p == 3) begin
        // only the high half changes in this phase
        drain_pipeline(4);
        write_reg(CFG_KEY_HIGH, {$urandom, $urandom});
      end else begin
        set_key({$urandom, $urandom}, {$urandom, $urandom});
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(3) == 0) begin
          send_block(DIR_DEC, last_cipher);
        end else begin
          dir = dir_e'($urandom_range(1));
          send_block(dir, rand_block());
        end
      end
    end
  endtask

  // Receiver holds off long enough for every stage to fill and stall the input.
  task automatic test_backpressure();
    tx_idle_pct = 0;
    hold_req    = 1'b1;
    for (int n = 0; n < 120; n++) send_block(dir_e'($urandom_range(1)), rand_block());
    tx_idle_pct = 24;
  endtask

  task automatic test_full_rate();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    for (int n = 0; n < 200; n++) send_block(dir_e'($urandom_range(1)), rand_block());
    tx_idle_pct = 24;
    rx_idle_pct = 24;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: checks each result beat and drives the output stall
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_blocks.size() == 0) begin
        $error("result_block: no beat expected, actual %h", result_block);
        mismatch_count++;
      end else begin
        want_block = pending_blocks.pop_front();
        if (result_block !== want_block) begin
          $error("result_block: expected %h, actual %h", want_block, result_block);
          mismatch_count++;
        end
      end
    end
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // Watchdog: cycles with no accepted beat on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);
    test_reset_key();
    test_key_extremes();
    test_random_traffic();
    test_backpressure();
    test_full_rate();
    drain_pipeline(DRAIN_TAIL);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/gift64_pkg.sv
src/gift64_round.sv
src/gift64_block_cipher.sv
tb/gift64_block_cipher_test.sv
